[src/cal_pkg.sv]
// Shared types and constants of the cumulative activity level meter.
`timescale 1ns / 1ps
package cal_pkg;

   // Number of lanes that carry stored counters.
   localparam int LANES = 4;
   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CNT_W = $clog2(LANES + 1);

   // Fixed field widths.
   localparam int LANE_FIELD_W = 3;
   localparam int MASK_W = 8;
   localparam int LEVEL_W = 16;

   // Log2 values are Q6.16; the frame term with its offset needs one more integer bit.
   localparam int LOG_W = 22;
   localparam int LF_W = 23;
   localparam logic [LF_W-1:0] LF_OFFSET = LF_W'(25 << 16);

   // log10(2)/8 in Q0.32 and the width of the scaled log difference.
   localparam int COEF_W = 28;
   localparam logic [COEF_W-1:0] LEVEL_COEF = COEF_W'(161614248);
   localparam int PROD_W = LF_W + COEF_W;

   // One memory entry: the pending snapshot and the baseline of a lane.
   typedef struct packed {
      logic [63:0] pend_e;
      logic [31:0] pend_t;
      logic [63:0] base_e;
      logic [31:0] base_t;
   } lane_entry_type;

   // Access request to the lane memory.
   typedef struct packed {
      logic           rd_en;
      logic [LANE_W-1:0] rd_addr;
      logic           we;
      logic [LANE_W-1:0] wr_addr;
      lane_entry_type wdata;
   } mem_req_type;

endpackage

[src/cal_lane_mem.sv]
// Lane memory: pending and baseline counters, one entry per lane, registered read.
`timescale 1ns / 1ps
module cal_lane_mem
   import cal_pkg::*;
(
   input  logic           clock,
   input  mem_req_type    mem_req,
   output lane_entry_type rd_data
);

   lane_entry_type mem_ff [LANES];
   lane_entry_type rdata_ff;

   // One write port and one read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

[src/cal_log2.sv]
// Iterative log2 unit: binary leading-one search, then sixteen squaring steps.
`timescale 1ns / 1ps
module cal_log2
   import cal_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      x,
   output logic             done,
   output logic [LOG_W-1:0] result
);

   typedef enum logic [2:0] {
      LG_IDLE = 3'b001,
      LG_NORM = 3'b010,
      LG_SQR  = 3'b100
   } lg_state_type;

   lg_state_type state_ff;
   logic [63:0]  v_ff;
   logic [5:0]   e_ff;
   logic [3:0]   step_ff;
   logic [31:0]  m_ff;
   logic [15:0]  frac_ff;
   logic         done_ff;

   logic        top_zero;
   logic [63:0] v_shift;
   logic [5:0]  e_dec;
   logic [63:0] v_in;
   logic [63:0] sq;
   logic [32:0] q;

   // One halving step of the leading-one search per cycle.
   always_comb begin
      case (step_ff[2:0])
         3'd0: begin
            top_zero = (v_ff[63:32] == '0);
            v_shift = {v_ff[31:0], 32'b0};
            e_dec = 6'd32;
         end
         3'd1: begin
            top_zero = (v_ff[63:48] == '0);
            v_shift = {v_ff[47:0], 16'b0};
            e_dec = 6'd16;
         end
         3'd2: begin
            top_zero = (v_ff[63:56] == '0);
            v_shift = {v_ff[55:0], 8'b0};
            e_dec = 6'd8;
         end
         3'd3: begin
            top_zero = (v_ff[63:60] == '0);
            v_shift = {v_ff[59:0], 4'b0};
            e_dec = 6'd4;
         end
         3'd4: begin
            top_zero = (v_ff[63:62] == '0);
            v_shift = {v_ff[61:0], 2'b0};
            e_dec = 6'd2;
         end
         3'd5: begin
            top_zero = !v_ff[63];
            v_shift = {v_ff[62:0], 1'b0};
            e_dec = 6'd1;
         end
         default: begin
            top_zero = 1'b0;
            v_shift = v_ff;
            e_dec = 6'd0;
         end
      endcase
      v_in = top_zero ? v_shift : v_ff;
   end

   // Squaring step on the Q1.31 mantissa.
   assign sq = m_ff * m_ff;
   assign q = sq[63:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            LG_IDLE: begin
               if (start) begin
                  v_ff <= x;
                  e_ff <= 6'd63;
                  step_ff <= '0;
                  state_ff <= LG_NORM;
               end
            end
            LG_NORM: begin
               v_ff <= v_in;
               if (top_zero) begin
                  e_ff <= e_ff - e_dec;
               end
               if (step_ff == 4'd5) begin
                  m_ff <= v_in[63:32];
                  frac_ff <= '0;
                  step_ff <= '0;
                  state_ff <= LG_SQR;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            LG_SQR: begin
               frac_ff <= {frac_ff[14:0], q[32]};
               m_ff <= q[32] ? q[32:1] : q[31:0];
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd15) begin
                  done_ff <= 1'b1;
                  state_ff <= LG_IDLE;
               end
            end
            default: state_ff <= LG_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign result = {e_ff, frac_ff};

endmodule

[src/cumulative_activity_level_meter.sv]
// Top level of the cumulative activity level meter: sequencer, baselines and result register.
//
// Usage: the req_ channel carries one lane of a counter snapshot per transaction, lanes in
// order, the last one marked by req_closes_snapshot together with the frame number, the
// cohesion energy and the clear count. The rsp_ channel returns results.
// A snapshot that follows a valid baseline without a counter drop returns one result per
// lane and a summary result; the first snapshot after reset, or one with a drop, returns a
// single rebased result and becomes the new baseline.
// Flow: a lane transaction that does not close a snapshot does a memory read, then a check
// and write back. A closing transaction that rebases then runs the baseline copy sweep over
// all lanes. A closing transaction with levels runs the shared log2 unit once for the
// frames and once for each lane and the cohesion, with read, multiply and emit steps around
// each lane's log2; the log2 unit sets the pace. The meter takes a new transaction only
// once it is back in idle.
// A rebased result is loaded in the rebase state, which follows the read; a per-lane result
// after the frame log2 and that lane's read, data, log2 and multiply steps.
// Reset (synchronous, active high) clears the baseline flag, so the next snapshot rebases;
// the lane memory needs no clearing.
// When the receiver stalls, the current result holds in the output register and the
// sequencer waits before loading the next one; req_stall stays high while busy.
`timescale 1ns / 1ps
module cumulative_activity_level_meter
   import cal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_lane_index,
   input  logic [63:0] req_lane_energy,
   input  logic [31:0] req_lane_triggers,
   input  logic [63:0] req_frame_index,
   input  logic [63:0] req_cohesion_energy,
   input  logic [31:0] req_clear_count,
   input  logic        req_closes_snapshot,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_summary,
   output logic [2:0]  rsp_out_lane,
   output logic [15:0] rsp_level,
   output logic [31:0] rsp_trigger_delta,
   output logic [63:0] rsp_frames_elapsed,
   output logic [7:0]  rsp_active_lanes,
   output logic        rsp_clear_flag,
   output logic        rsp_rebased,
   output logic        rsp_last_result
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RD    = 11'b00000000010,
      S_REB   = 11'b00000000100,
      S_SWR   = 11'b00000001000,
      S_SWW   = 11'b00000010000,
      S_LOGF  = 11'b00000100000,
      S_LRD   = 11'b00001000000,
      S_LDAT  = 11'b00010000000,
      S_LLOG  = 11'b00100000000,
      S_LMUL  = 11'b01000000000,
      S_LEMIT = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Captured transaction.
   logic [2:0]  it_lane_ff;
   logic [63:0] it_energy_ff;
   logic [31:0] it_trig_ff;
   logic [63:0] it_frame_ff;
   logic [63:0] it_coh_ff;
   logic [31:0] it_clr_ff;
   logic        it_close_ff;

   // Baselines held in registers.
   logic        have_base_ff;
   logic        drop_seen_ff;
   logic [63:0] base_frame_ff;
   logic [63:0] base_coh_ff;
   logic [31:0] base_clr_ff;

   // Working registers of the level pass.
   logic [CNT_W-1:0]  cnt_ff;
   logic [63:0]       frames_ff;
   logic              fz_ff;
   logic              vz_ff;
   logic [LF_W-1:0]   lf_ff;
   logic [LOG_W-1:0]  le_ff;
   logic              sat_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [31:0]       td_ff;
   logic [MASK_W-1:0] mask_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_is_summary_ff;
   logic [2:0]  rsp_out_lane_ff;
   logic [15:0] rsp_level_ff;
   logic [31:0] rsp_trigger_delta_ff;
   logic [63:0] rsp_frames_elapsed_ff;
   logic [7:0]  rsp_active_lanes_ff;
   logic        rsp_clear_flag_ff;
   logic        rsp_rebased_ff;
   logic        rsp_last_result_ff;

   mem_req_type      mem_req;
   lane_entry_type   rd_data;
   logic             log_start;
   logic [63:0]      log_x;
   logic             log_done;
   logic [LOG_W-1:0] log_result;

   logic              req_accept;
   logic              out_free;
   logic              rsp_load;
   logic              lane_ok;
   logic              at_cohesion;
   logic [LANE_W-1:0] cnt_addr;
   logic              drop_new;
   logic              rollback;
   logic [63:0]       frames_calc;
   logic [63:0]       val_calc;
   logic [31:0]       dt_calc;
   logic [52:0]       drop_sum;
   logic [20:0]       drop;
   logic [15:0]       level_calc;

   cal_lane_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cal_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_result)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = out_free && (state_ff == S_REB || state_ff == S_LEMIT);
   assign lane_ok = ({1'b0, it_lane_ff} < 4'(LANES));
   assign at_cohesion = (cnt_ff == CNT_W'(LANES));
   assign cnt_addr = cnt_ff[LANE_W-1:0];

   // Rollback detection on the stored baselines.
   assign drop_new = lane_ok && have_base_ff &&
                     (it_energy_ff < rd_data.base_e || it_trig_ff < rd_data.base_t);
   assign rollback = have_base_ff && (drop_seen_ff || drop_new ||
                     it_frame_ff < base_frame_ff || it_coh_ff < base_coh_ff ||
                     it_clr_ff < base_clr_ff);

   // Deltas against the baseline.
   assign frames_calc = it_frame_ff - base_frame_ff;
   assign val_calc = at_cohesion ? (it_coh_ff - base_coh_ff)
                                 : (rd_data.pend_e - rd_data.base_e);
   assign dt_calc = rd_data.pend_t - rd_data.base_t;

   // Level from the scaled log difference, rounded to nearest, then clamped.
   assign drop_sum = {2'b0, prod_ff} + 53'(64'h8000_0000);
   assign drop = drop_sum[52:32];
   always_comb begin
      if (fz_ff || vz_ff) begin
         level_calc = '0;
      end else if (sat_ff || drop == '0) begin
         level_calc = 16'hFFFF;
      end else if (drop >= 21'h10000) begin
         level_calc = '0;
      end else begin
         level_calc = 16'(17'h10000 - drop[16:0]);
      end
   end

   // Memory accesses and log2 launches by state.
   always_comb begin
      mem_req = '0;
      log_start = 1'b0;
      log_x = val_calc;
      unique case (state_ff)
         S_IDLE: begin
            mem_req.rd_en = req_accept;
            mem_req.rd_addr = req_lane_index[LANE_W-1:0];
         end
         S_RD: begin
            mem_req.we = lane_ok;
            mem_req.wr_addr = it_lane_ff[LANE_W-1:0];
            mem_req.wdata = '{pend_e: it_energy_ff, pend_t: it_trig_ff,
                              base_e: rd_data.base_e, base_t: rd_data.base_t};
            log_x = frames_calc;
            log_start = it_close_ff && have_base_ff && !rollback;
         end
         S_SWR: begin
            mem_req.rd_en = 1'b1;
            mem_req.rd_addr = cnt_addr;
         end
         S_SWW: begin
            mem_req.we = 1'b1;
            mem_req.wr_addr = cnt_addr;
            mem_req.wdata = '{pend_e: rd_data.pend_e, pend_t: rd_data.pend_t,
                              base_e: rd_data.pend_e, base_t: rd_data.pend_t};
         end
         S_LRD: begin
            mem_req.rd_en = !at_cohesion;
            mem_req.rd_addr = cnt_addr;
         end
         S_LDAT: begin
            mem_req.we = !at_cohesion;
            mem_req.wr_addr = cnt_addr;
            mem_req.wdata = '{pend_e: rd_data.pend_e, pend_t: rd_data.pend_t,
                              base_e: rd_data.pend_e, base_t: rd_data.pend_t};
            log_start = 1'b1;
         end
         S_LOGF, S_REB, S_LLOG, S_LMUL, S_LEMIT: begin
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_accept) state_in = S_RD;
         S_RD: begin
            if (!it_close_ff) begin
               state_in = S_IDLE;
            end else if (!have_base_ff || rollback) begin
               state_in = S_REB;
            end else begin
               state_in = S_LOGF;
            end
         end
         S_REB:   if (out_free) state_in = S_SWR;
         S_SWR:   state_in = S_SWW;
         S_SWW:   state_in = (cnt_ff == CNT_W'(LANES - 1)) ? S_IDLE : S_SWR;
         S_LOGF:  if (log_done) state_in = S_LRD;
         S_LRD:   state_in = S_LDAT;
         S_LDAT:  state_in = S_LLOG;
         S_LLOG:  if (log_done) state_in = S_LMUL;
         S_LMUL:  state_in = S_LEMIT;
         S_LEMIT: begin
            if (out_free) begin
               state_in = at_cohesion ? S_IDLE : S_LRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         have_base_ff <= 1'b0;
         drop_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         // A new result replaces the one that leaves in the same cycle.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_RD: begin
               drop_seen_ff <= drop_seen_ff || drop_new;
            end
            S_REB: begin
               if (out_free) begin
                  have_base_ff <= 1'b1;
                  drop_seen_ff <= 1'b0;
                  cnt_ff <= '0;
               end
            end
            S_SWW: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            S_LOGF: begin
               if (log_done) begin
                  cnt_ff <= '0;
               end
            end
            S_LEMIT: begin
               if (out_free) begin
                  if (at_cohesion) begin
                     have_base_ff <= 1'b1;
                     drop_seen_ff <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                  end
               end
            end
            S_IDLE, S_SWR, S_LRD, S_LDAT, S_LLOG, S_LMUL: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         it_lane_ff <= req_lane_index;
         it_energy_ff <= req_lane_energy;
         it_trig_ff <= req_lane_triggers;
         it_frame_ff <= req_frame_index;
         it_coh_ff <= req_cohesion_energy;
         it_clr_ff <= req_clear_count;
         it_close_ff <= req_closes_snapshot;
      end
      case (state_ff)
         S_RD: begin
            frames_ff <= frames_calc;
            fz_ff <= (frames_calc == '0);
            mask_ff <= '0;
         end
         S_REB: begin
            if (out_free) begin
               rsp_is_summary_ff <= 1'b1;
               rsp_out_lane_ff <= '0;
               rsp_level_ff <= '0;
               rsp_trigger_delta_ff <= '0;
               rsp_frames_elapsed_ff <= '0;
               rsp_active_lanes_ff <= '0;
               rsp_clear_flag_ff <= 1'b0;
               rsp_rebased_ff <= have_base_ff;
               rsp_last_result_ff <= 1'b1;
               base_frame_ff <= it_frame_ff;
               base_coh_ff <= it_coh_ff;
               base_clr_ff <= it_clr_ff;
            end
         end
         S_LOGF: begin
            if (log_done) begin
               lf_ff <= LF_W'(log_result) + LF_OFFSET;
            end
         end
         S_LDAT: begin
            vz_ff <= (val_calc == '0);
            if (!at_cohesion) begin
               td_ff <= dt_calc;
               if (dt_calc != '0) begin
                  mask_ff[cnt_addr] <= 1'b1;
               end
            end
         end
         S_LLOG: begin
            if (log_done) begin
               le_ff <= log_result;
            end
         end
         S_LMUL: begin
            sat_ff <= (LF_W'(le_ff) >= lf_ff);
            prod_ff <= PROD_W'(lf_ff - LF_W'(le_ff)) * PROD_W'(LEVEL_COEF);
         end
         S_LEMIT: begin
            if (out_free) begin
               rsp_level_ff <= level_calc;
               rsp_frames_elapsed_ff <= frames_ff;
               rsp_rebased_ff <= 1'b0;
               if (at_cohesion) begin
                  rsp_is_summary_ff <= 1'b1;
                  rsp_out_lane_ff <= '0;
                  rsp_trigger_delta_ff <= '0;
                  rsp_active_lanes_ff <= mask_ff;
                  rsp_clear_flag_ff <= (it_clr_ff > base_clr_ff);
                  rsp_last_result_ff <= 1'b1;
                  base_frame_ff <= it_frame_ff;
                  base_coh_ff <= it_coh_ff;
                  base_clr_ff <= it_clr_ff;
               end else begin
                  rsp_is_summary_ff <= 1'b0;
                  rsp_out_lane_ff <= LANE_FIELD_W'(cnt_ff);
                  rsp_trigger_delta_ff <= td_ff;
                  rsp_active_lanes_ff <= '0;
                  rsp_clear_flag_ff <= 1'b0;
                  rsp_last_result_ff <= 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_summary = rsp_is_summary_ff;
   assign rsp_out_lane = rsp_out_lane_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_trigger_delta = rsp_trigger_delta_ff;
   assign rsp_frames_elapsed = rsp_frames_elapsed_ff;
   assign rsp_active_lanes = rsp_active_lanes_ff;
   assign rsp_clear_flag = rsp_clear_flag_ff;
   assign rsp_rebased = rsp_rebased_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // A per-lane result never closes a snapshot.
   a_lane_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_summary |-> !rsp_last_result)
      else $error("per-lane result marked as last");

   // A rebased result is a lone summary without a level.
   a_rebased_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rebased |-> rsp_is_summary && rsp_last_result && rsp_level == '0)
      else $error("malformed rebased result");

   // The log2 unit only finishes while the sequencer waits for it.
   a_log_done_state: assert property (@(posedge clock) disable iff (reset)
      log_done |-> state_ff == S_LOGF || state_ff == S_LLOG)
      else $error("log2 result arrived outside a wait state");

   // The lane counter never runs past the cohesion step.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LANES))
      else $error("lane counter out of range");

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the cumulative activity level meter.
`timescale 1ns / 1ps
module tb_top;
   import cal_pkg::*;

   // One snapshot transaction on the request channel.
   typedef struct {
      bit [2:0]  lane;
      bit [63:0] energy;
      bit [31:0] trig;
      bit [63:0] frame;
      bit [63:0] coh;
      bit [31:0] clr;
      bit        close;
   } snap_item_type;

   // One result transaction on the response channel.
   typedef struct {
      bit        is_summary;
      bit [2:0]  out_lane;
      bit [15:0] level;
      bit [31:0] trigger_delta;
      bit [63:0] frames_elapsed;
      bit [7:0]  active_lanes;
      bit        clear_flag;
      bit        rebased;
      bit        last_result;
   } meter_result_type;

   // A rebase answer typed in by hand for a directed row.
   typedef struct {
      bit               valid;
      meter_result_type res;
   } typed_rebase_type;

   // A directed stimulus row.
   typedef struct {
      snap_item_type item;
      bit            typed;
      bit            reb;
   } dir_row_type;

   localparam bit [63:0] LEVEL_MULT = 64'd161614248;
   localparam bit [63:0] E_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam bit [63:0] E_ONE = 64'h0000_0000_0100_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_lane_index = '0;
   logic [63:0] req_lane_energy = '0;
   logic [31:0] req_lane_triggers = '0;
   logic [63:0] req_frame_index = '0;
   logic [63:0] req_cohesion_energy = '0;
   logic [31:0] req_clear_count = '0;
   logic        req_closes_snapshot = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_summary;
   logic [2:0]  rsp_out_lane;
   logic [15:0] rsp_level;
   logic [31:0] rsp_trigger_delta;
   logic [63:0] rsp_frames_elapsed;
   logic [7:0]  rsp_active_lanes;
   logic        rsp_clear_flag;
   logic        rsp_rebased;
   logic        rsp_last_result;

   cumulative_activity_level_meter dut (.*);

   always #6 clock = ~clock;

   // Predictor state: baseline and pending lane counters.
   bit            have_base;
   bit [63:0]     base_frame_q;
   bit [63:0]     base_energy_q [LANES];
   bit [31:0]     base_trig_q [LANES];
   bit [63:0]     base_coh_q;
   bit [31:0]     base_clr_q;
   bit [63:0]     pend_energy_q [LANES];
   bit [31:0]     pend_trig_q [LANES];
   bit            drop_flag;

   meter_result_type expected_results [$];
   typed_rebase_type typed_rebases [$];
   dir_row_type      dir_tab [$];

   int  fail_count;
   int  items_taken;
   int  snaps_closed;
   int  rebase_count;
   int  results_checked;
   bit  quiet;
   bit  hold_request;
   bit  hold_sent;

   // Log2 of x >= 1 in Q6.16, fraction by repeated squaring of the mantissa.
   function automatic bit [63:0] log2_fix(bit [63:0] x);
      int        e;
      bit [63:0] m;
      bit [63:0] frac;
      e = 63;
      while (e > 0 && !x[e]) e--;
      m = (x << (63 - e)) >> 32;
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << 16) | frac;
   endfunction

   // Display level of an energy delta over a frame count.
   function automatic bit [15:0] level_for(bit [63:0] energy, bit [63:0] frames);
      bit [63:0] le;
      bit [63:0] lf;
      bit [63:0] drop;
      if (energy == 0 || frames == 0) return 16'd0;
      le = log2_fix(energy);
      lf = log2_fix(frames) + (64'd25 << 16);
      if (le >= lf) return 16'hFFFF;
      drop = ((lf - le) * LEVEL_MULT + (64'd1 << 31)) >> 32;
      if (drop >= 64'd65536) return 16'd0;
      if (drop == 0) return 16'hFFFF;
      return 16'(64'd65536 - drop);
   endfunction

   // Copy the pending snapshot into the baseline.
   function automatic void rebaseline(bit [63:0] frame, bit [63:0] coh, bit [31:0] clr);
      base_frame_q = frame;
      for (int i = 0; i < LANES; i++) begin
         base_energy_q[i] = pend_energy_q[i];
         base_trig_q[i] = pend_trig_q[i];
      end
      base_coh_q = coh;
      base_clr_q = clr;
      have_base = 1'b1;
      drop_flag = 1'b0;
   endfunction

   // Work out the results of one accepted transaction and queue them.
   function automatic void predict_levels(snap_item_type it, typed_rebase_type tr);
      meter_result_type r;
      bit [63:0]        frames;
      bit [7:0]         mask;
      bit [31:0]        dt;
      bit               rollback;
      if (it.lane < LANES) begin
         if (have_base && (it.energy < base_energy_q[it.lane] ||
                           it.trig < base_trig_q[it.lane]))
            drop_flag = 1'b1;
         pend_energy_q[it.lane] = it.energy;
         pend_trig_q[it.lane] = it.trig;
      end
      if (!it.close) return;
      snaps_closed++;
      rollback = have_base && (drop_flag || it.frame < base_frame_q ||
                               it.coh < base_coh_q || it.clr < base_clr_q);
      if (!have_base || rollback) begin
         r = '{default: 0};
         r.is_summary = 1'b1;
         r.rebased = have_base;
         r.last_result = 1'b1;
         expected_results.push_back(tr.valid ? tr.res : r);
         rebase_count++;
         rebaseline(it.frame, it.coh, it.clr);
         return;
      end
      frames = it.frame - base_frame_q;
      mask = '0;
      for (int i = 0; i < LANES; i++) begin
         dt = pend_trig_q[i] - base_trig_q[i];
         if (dt != 0) mask[i] = 1'b1;
         r = '{default: 0};
         r.out_lane = 3'(i);
         r.level = level_for(pend_energy_q[i] - base_energy_q[i], frames);
         r.trigger_delta = dt;
         r.frames_elapsed = frames;
         expected_results.push_back(r);
      end
      r = '{default: 0};
      r.is_summary = 1'b1;
      r.level = level_for(it.coh - base_coh_q, frames);
      r.frames_elapsed = frames;
      r.active_lanes = mask;
      r.clear_flag = it.clr > base_clr_q;
      r.last_result = 1'b1;
      expected_results.push_back(r);
      rebaseline(it.frame, it.coh, it.clr);
   endfunction

   // Request monitor: feed every accepted transaction to the predictor.
   always @(posedge clock) begin
      snap_item_type    it;
      typed_rebase_type tr;
      if (!reset && req_valid && !req_stall) begin
         it = '{req_lane_index, req_lane_energy, req_lane_triggers, req_frame_index,
                req_cohesion_energy, req_clear_count, req_closes_snapshot};
         tr = typed_rebases.pop_front();
         items_taken++;
         predict_levels(it, tr);
      end
   end

   // Response monitor: compare each result with the oldest expectation.
   always @(posedge clock) begin
      meter_result_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            fail_count++;
         end else begin
            x = expected_results.pop_front();
            results_checked++;
            if (rsp_is_summary !== x.is_summary) begin
               $error("is_summary: expected %0d, got %0d", x.is_summary, rsp_is_summary);
               fail_count++;
            end
            if (rsp_out_lane !== x.out_lane) begin
               $error("out_lane: expected %0d, got %0d", x.out_lane, rsp_out_lane);
               fail_count++;
            end
            if (rsp_level !== x.level) begin
               $error("level: expected %0d, got %0d", x.level, rsp_level);
               fail_count++;
            end
            if (rsp_trigger_delta !== x.trigger_delta) begin
               $error("trigger_delta: expected %0d, got %0d", x.trigger_delta,
                      rsp_trigger_delta);
               fail_count++;
            end
            if (rsp_frames_elapsed !== x.frames_elapsed) begin
               $error("frames_elapsed: expected %0d, got %0d", x.frames_elapsed,
                      rsp_frames_elapsed);
               fail_count++;
            end
            if (rsp_active_lanes !== x.active_lanes) begin
               $error("active_lanes: expected %0h, got %0h", x.active_lanes,
                      rsp_active_lanes);
               fail_count++;
            end
            if (rsp_clear_flag !== x.clear_flag) begin
               $error("clear_flag: expected %0d, got %0d", x.clear_flag,
                      rsp_clear_flag);
               fail_count++;
            end
            if (rsp_rebased !== x.rebased) begin
               $error("rebased: expected %0d, got %0d", x.rebased, rsp_rebased);
               fail_count++;
            end
            if (rsp_last_result !== x.last_result) begin
               $error("last_result: expected %0d, got %0d", x.last_result,
                      rsp_last_result);
               fail_count++;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   always @(negedge clock) begin
      int stall_left;
      int hold_left;
      if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one transaction, with an optional idle burst first, until accepted.
   task automatic send_snap(snap_item_type it, typed_rebase_type tr);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_rebases.push_back(tr);
      req_valid <= 1'b1;
      req_lane_index <= it.lane;
      req_lane_energy <= it.energy;
      req_lane_triggers <= it.trig;
      req_frame_index <= it.frame;
      req_cohesion_energy <= it.coh;
      req_clear_count <= it.clr;
      req_closes_snapshot <= it.close;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Random value with its magnitude spread from one bit up to 64 - lo_shift bits.
   function automatic bit [63:0] spread64(int lo_shift);
      return {$urandom, $urandom} >> $urandom_range(lo_shift, 63);
   endfunction

   // Directed table, then well-formed random snapshots with rollbacks and noise.
   initial begin
      typed_rebase_type tr;
      snap_item_type    it;
      snap_item_type    snap [$];
      bit [63:0]        cur_e [LANES];
      bit [31:0]        cur_t [LANES];
      bit [63:0]        cur_frame;
      bit [63:0]        cur_coh;
      bit [31:0]        cur_clr;
      int               rnd_items;
      int               ln;

      // First capture after reset: every lane written, answers a plain rebase.
      dir_tab.push_back('{'{3'd0, 64'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd1, 64'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd2, 64'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd3, 64'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b1}, 1'b1, 1'b0});
      // Zero delta, saturating maxima, unit energy and the smallest energy over one frame.
      dir_tab.push_back('{'{3'd0, 64'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd1, E_MAX, 32'hFFFF_FFFF, E_MAX, E_MAX, '1, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd2, E_ONE, 32'd5, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd3, 64'd1, 32'd1, 64'd1, E_MAX, 32'd1, 1'b1}, 1'b0, 1'b0});
      // Lane out of range ignored, lane sent twice, zero frames, close on a spare lane.
      dir_tab.push_back('{'{3'd5, E_MAX, '1, E_MAX, E_MAX, '1, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd0, 64'd10, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd0, 64'd20, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd7, 64'd0, 32'd0, 64'd1, E_MAX, 32'd1, 1'b1}, 1'b0, 1'b0});
      // A drop that is undone by a resend still rolls back.
      dir_tab.push_back('{'{3'd2, 64'd0, 32'd5, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd2, 2 * E_ONE, 32'd5, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd3, 64'd1, 32'd1, 64'd2, E_MAX, 32'd1, 1'b1}, 1'b1, 1'b1});
      // Rollback by frame, by clear count and by cohesion energy.
      dir_tab.push_back('{'{3'd0, 64'd20, 32'd0, 64'd1, E_MAX, 32'd1, 1'b1}, 1'b1, 1'b1});
      dir_tab.push_back('{'{3'd0, 64'd20, 32'd0, 64'd5, E_MAX, 32'd0, 1'b1}, 1'b1, 1'b1});
      dir_tab.push_back('{'{3'd0, 64'd20, 32'd0, 64'd6, 64'd0, 32'd0, 1'b1}, 1'b1, 1'b1});
      // Largest deltas and the largest frame count.
      dir_tab.push_back('{'{3'd0, E_MAX, 32'hFFFF_FFFF, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd1, E_MAX, 32'hFFFF_FFFF, 64'd0, 64'd0, 32'd0, 1'b0}, 1'b0, 1'b0});
      dir_tab.push_back('{'{3'd2, 64'h8000_0000_0000_0000, 32'd6, 64'd0, 64'd0, 32'd0, 1'b0},
                         1'b0, 1'b0});
      dir_tab.push_back('{'{3'd3, 64'd1, 32'd1, E_MAX, 64'h8000_0000_0000_0000,
                            32'hFFFF_FFFF, 1'b1}, 1'b0, 1'b0});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) begin
         tr.valid = dir_tab[i].typed;
         tr.res = '{default: 0};
         tr.res.is_summary = 1'b1;
         tr.res.rebased = dir_tab[i].reb;
         tr.res.last_result = 1'b1;
         send_snap(dir_tab[i].item, tr);
      end

      // Random part: cumulative counters that mostly grow.
      tr = '{default: 0};
      for (int i = 0; i < LANES; i++) begin
         cur_e[i] = spread64(8);
         cur_t[i] = $urandom >> $urandom_range(0, 31);
      end
      cur_frame = spread64(16);
      cur_coh = spread64(8);
      cur_clr = $urandom_range(0, 100);
      rnd_items = 0;
      while (rnd_items < 248) begin
         if (rnd_items >= 100 && !hold_sent) begin
            hold_request = 1'b1;
            hold_sent = 1'b1;
         end
         if (rnd_items >= 210) quiet = 1'b1;
         // Occasionally jump all counters to fresh values.
         if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < LANES; i++) begin
               cur_e[i] = {$urandom, $urandom};
               cur_t[i] = $urandom;
            end
            cur_frame = {$urandom, $urandom};
            cur_coh = {$urandom, $urandom};
            cur_clr = $urandom;
         end
         for (int i = 0; i < LANES; i++) begin
            cur_e[i] += spread64(12);
            if ($urandom_range(0, 3) != 0) cur_t[i] += $urandom >> $urandom_range(8, 31);
         end
         cur_frame += (64'($urandom) >> $urandom_range(16, 31));
         cur_coh += spread64(12);
         cur_clr += $urandom_range(0, 1);
         // Broken snapshots: one counter steps back.
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 4))
               0: cur_e[$urandom_range(0, LANES - 1)] -= 64'd1;
               1: cur_t[$urandom_range(0, LANES - 1)] -= 32'd1;
               2: cur_frame -= 64'd1;
               3: cur_coh -= 64'd1;
               default: cur_clr -= 32'd1;
            endcase
         end
         snap.delete();
         for (int i = 0; i < LANES; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               ln = $urandom_range(LANES, 7);
               snap.push_back('{3'(ln), {$urandom, $urandom}, $urandom, {$urandom, $urandom},
                                {$urandom, $urandom}, $urandom, 1'b0});
            end
            if ($urandom_range(0, 9) != 0)
               snap.push_back('{3'(i), cur_e[i], cur_t[i], {$urandom, $urandom},
                                {$urandom, $urandom}, $urandom, 1'b0});
         end
         if (snap.size() == 0)
            snap.push_back('{3'd0, cur_e[0], cur_t[0], 64'd0, 64'd0, 32'd0, 1'b0});
         snap[snap.size() - 1].frame = cur_frame;
         snap[snap.size() - 1].coh = cur_coh;
         snap[snap.size() - 1].clr = cur_clr;
         snap[snap.size() - 1].close = 1'b1;
         foreach (snap[k]) begin
            it = snap[k];
            send_snap(it, tr);
            rnd_items++;
         end
      end
      req_valid <= 1'b0;

      // Drain the remaining results, then allow the pipeline to settle.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end
      $display("Run covered %0d request transactions in %0d snapshots (%0d rebased).",
               items_taken, snaps_closed, rebase_count);
      $display("Checked %0d result transactions against the predictor.", results_checked);
      if (fail_count == 0) begin
         $display("** cumulative_activity_level_meter: PASSED **");
      end else begin
         $display("** cumulative_activity_level_meter: FAILED **");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #5_000_000;
      $display("** cumulative_activity_level_meter: FAILED **");
      $finish;
   end

endmodule
